// ----- src/owm_pkg.sv -----
// Shared types and constants for the single-wire bus master slot engine.
// Used by owm_front, owm_back and onewire_master_slot_engine_unit; no dependencies.
package owm_pkg;

  // Width of the tick counter and of the timing registers.
  localparam int CNT_W = 16;

  // Depth of the queue between the front and the back, and its pointer width.
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = CNT_W;

  localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENCE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT      = 2'd2;

  localparam logic [CNT_W-1:0] RESET_LOW_DEFAULT = CNT_W'(480);
  localparam logic [CNT_W-1:0] PRESENCE_DEFAULT  = CNT_W'(480);
  localparam logic [CNT_W-1:0] SLOT_DEFAULT      = CNT_W'(60);

  // Stream widths.
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [7:0] {
    PH_IDLE     = 8'b0000_0001,
    PH_RST_LOW  = 8'b0000_0010,
    PH_RST_WAIT = 8'b0000_0100,
    PH_LOW      = 8'b0000_1000,
    PH_VALUE    = 8'b0001_0000,
    PH_REL      = 8'b0010_0000,
    PH_SAMPLE   = 8'b0100_0000,
    PH_WAIT     = 8'b1000_0000
  } phase_t;

  // One tick as queued between front and back.
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] write_data;
    logic       line_level;
  } item_t;

  // One result beat; drive_enable sits in the lowest bit when packed.
  typedef struct packed {
    logic [7:0] read_data;
    logic       presence_seen;
    logic       done_res;
    logic       busy_res;
    logic       drive_level;
    logic       drive_enable;
  } res_t;

  localparam int RES_W = $bits(res_t);

  // Counter load for a phase of n ticks: n - 1, with zero acting as one.
  function automatic logic [CNT_W-1:0] load_of(input logic [CNT_W-1:0] n);
    load_of = (n == '0) ? '0 : n - CNT_W'(1);
  endfunction

endpackage

// ----- src/owm_front.sv -----
// Front part of the slot engine: accepts tick beats, decodes the command and
// holds them in a short queue for the back part. Depends on owm_pkg.
module owm_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [owm_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic [owm_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                           q_valid,
  output owm_pkg::item_t                 q_item,
  input  logic                           q_pop
);
  import owm_pkg::*;

  item_t           queue [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;
  logic            push;
  logic            pop;
  item_t           in_item;

  always_comb begin
    unique case (s_tuser)
      CMD_RESET: in_item.cmd = CMD_RESET;
      CMD_WRITE: in_item.cmd = CMD_WRITE;
      CMD_READ:  in_item.cmd = CMD_READ;
      default:   in_item.cmd = CMD_NONE;
    endcase
    in_item.write_data = s_tdata[7:0];
    in_item.line_level = s_tdata[8];
  end

  assign s_tready = (count != (Q_AW+1)'(Q_DEPTH));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (Q_AW+1)'(1);
        2'b01:   count <= count - (Q_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- src/owm_back.sv -----
// Back part of the slot engine: timing registers, the bit-slot state machine
// and the output register. Depends on owm_pkg.
module owm_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [owm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [owm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            q_valid,
  input  owm_pkg::item_t                  q_item,
  output logic                            q_pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [owm_pkg::OUT_DATA_W-1:0]  m_tdata
);
  import owm_pkg::*;

  logic [CNT_W-1:0] reset_low_ticks;
  logic [CNT_W-1:0] presence_window_ticks;
  logic [CNT_W-1:0] slot_ticks;

  phase_t           phase, phase_cur, phase_next;
  cmd_t             cmd, cmd_cur;
  logic [CNT_W-1:0] tick_count, cnt_cur, tick_count_next;
  logic [2:0]       bit_index, bidx_cur, bit_index_next;
  logic [7:0]       shift_byte, shift_cur, shift_byte_next;
  logic             presence_flag, pres_cur, presence_flag_next;
  logic [7:0]       last_read, last_read_next;
  logic             end_bit;
  res_t             res, res_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_low_ticks       <= RESET_LOW_DEFAULT;
      presence_window_ticks <= PRESENCE_DEFAULT;
      slot_ticks            <= SLOT_DEFAULT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RESET_LOW: reset_low_ticks       <= cfg_data;
        REG_PRESENCE:  presence_window_ticks <= cfg_data;
        REG_SLOT:      slot_ticks            <= cfg_data;
        default:       ;
      endcase
    end
  end

  assign q_pop = q_valid && (!m_tvalid || m_tready);

  // A command seen while idle starts in the same tick.
  always_comb begin
    phase_cur = phase;
    cmd_cur   = cmd;
    cnt_cur   = tick_count;
    bidx_cur  = bit_index;
    shift_cur = shift_byte;
    pres_cur  = presence_flag;
    if (phase == PH_IDLE && q_item.cmd != CMD_NONE) begin
      cmd_cur  = q_item.cmd;
      bidx_cur = '0;
      if (q_item.cmd == CMD_RESET) begin
        pres_cur  = 1'b0;
        phase_cur = PH_RST_LOW;
        cnt_cur   = load_of(reset_low_ticks);
      end else begin
        if (q_item.cmd == CMD_WRITE) begin
          shift_cur = q_item.write_data;
        end
        phase_cur = PH_LOW;
        cnt_cur   = '0;
      end
    end
  end

  always_comb begin
    phase_next         = phase_cur;
    tick_count_next    = cnt_cur;
    bit_index_next     = bidx_cur;
    shift_byte_next    = shift_cur;
    presence_flag_next = pres_cur;
    last_read_next     = last_read;
    end_bit            = 1'b0;
    res                = '0;
    res.busy_res       = (phase_cur != PH_IDLE);

    unique case (phase_cur)
      PH_RST_LOW: begin
        res.drive_enable = 1'b1;
        if (cnt_cur == '0) begin
          phase_next      = PH_RST_WAIT;
          tick_count_next = load_of(presence_window_ticks);
        end else begin
          tick_count_next = cnt_cur - CNT_W'(1);
        end
      end
      PH_RST_WAIT: begin
        if (!q_item.line_level) begin
          presence_flag_next = 1'b1;
        end
        if (cnt_cur == '0) begin
          res.done_res = 1'b1;
          phase_next   = PH_IDLE;
        end else begin
          tick_count_next = cnt_cur - CNT_W'(1);
        end
      end
      PH_LOW: begin
        res.drive_enable = 1'b1;
        if (cmd_cur == CMD_WRITE) begin
          phase_next      = PH_VALUE;
          tick_count_next = load_of(slot_ticks);
        end else begin
          phase_next = PH_REL;
        end
      end
      PH_VALUE: begin
        res.drive_enable = 1'b1;
        res.drive_level  = shift_cur[0];
        if (cnt_cur == '0) begin
          phase_next = PH_REL;
        end else begin
          tick_count_next = cnt_cur - CNT_W'(1);
        end
      end
      PH_REL: begin
        if (cmd_cur == CMD_WRITE) begin
          shift_byte_next = {1'b0, shift_cur[7:1]};
          end_bit         = 1'b1;
        end else begin
          phase_next = PH_SAMPLE;
        end
      end
      PH_SAMPLE: begin
        shift_byte_next = {q_item.line_level, shift_cur[7:1]};
        if (slot_ticks <= CNT_W'(2)) begin
          end_bit = 1'b1;
        end else begin
          phase_next      = PH_WAIT;
          tick_count_next = slot_ticks - CNT_W'(3);
        end
      end
      PH_WAIT: begin
        if (cnt_cur == '0) begin
          end_bit = 1'b1;
        end else begin
          tick_count_next = cnt_cur - CNT_W'(1);
        end
      end
      default: ;
    endcase

    if (end_bit) begin
      if (bidx_cur == 3'd7) begin
        if (cmd_cur == CMD_READ) begin
          last_read_next = shift_byte_next;
        end
        res.done_res = 1'b1;
        phase_next   = PH_IDLE;
      end else begin
        bit_index_next = bidx_cur + 3'd1;
        phase_next     = PH_LOW;
      end
    end

    res.presence_seen = presence_flag_next;
    res.read_data     = last_read_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      cmd           <= CMD_NONE;
      tick_count    <= '0;
      bit_index     <= '0;
      shift_byte    <= '0;
      presence_flag <= 1'b0;
      last_read     <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (q_pop) begin
        phase         <= phase_next;
        cmd           <= cmd_cur;
        tick_count    <= tick_count_next;
        bit_index     <= bit_index_next;
        shift_byte    <= shift_byte_next;
        presence_flag <= presence_flag_next;
        last_read     <= last_read_next;
        m_tvalid      <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_reg <= res;
    end
  end

  assign m_tdata = {(OUT_DATA_W-RES_W)'(0), res_reg};

endmodule

// ----- src/onewire_master_slot_engine_unit.sv -----
// A tick beat accepted by the front is written into the queue, then popped into the output
// register once that register is free or being emptied, and leaves from there as a result beat.
// Throughput: one tick beat per cycle while the output accepts; the slot state machine in
// owm_back handles one tick per cycle and the two-entry queue absorbs output stalls.
// Reset (rst, synchronous): bus idle, flags and read byte cleared, timing registers
// back to 480 / 480 / 60 ticks.
module onewire_master_slot_engine_unit (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration: index 0 reset_low_ticks, 1 presence_window_ticks, 2 slot_ticks.
  input  logic                            cfg_we,
  input  logic [owm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [owm_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Tick input, one beat per microsecond tick.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // s_tdata from bit 0: write_data[7:0], line_level, zero fill.
  input  logic [owm_pkg::IN_DATA_W-1:0]   s_tdata,
  // s_tuser: operation[1:0] (0 none, 1 bus reset, 2 write byte, 3 read byte).
  input  logic [owm_pkg::IN_USER_W-1:0]   s_tuser,
  // Result output, one beat per tick beat.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata from bit 0: drive_enable, drive_level, busy_res, done_res,
  // presence_seen, read_data[7:0], zero fill.
  output logic [owm_pkg::OUT_DATA_W-1:0]  m_tdata
);
  import owm_pkg::*;

  // The front takes tick beats, decodes the operation and queues them. The back
  // pops one queued tick whenever its output register is free or being emptied,
  // steps the slot state machine and registers the result.
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  owm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // The back holds the timing registers, since only the state machine reads them.
  // Reads sample the line on the tick after the release tick, and write bits drive
  // the bit value actively for a full slot.
  owm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // A finished command is always reported on a busy tick.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[3]) |-> m_tdata[2])
    else $error("done without busy");

  // The master only drives high while it is driving at all.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1]) |-> m_tdata[0])
    else $error("drive level set while released");

  // An accepted tick beat is in the queue at the next edge.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> q_valid)
    else $error("accepted beat lost from queue");

  // The back never pops an empty queue.
  assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking bench for onewire_master_slot_engine_unit: tick beats go in and drive beats
// are compared, field by field, against a tick-accurate predictor of the slot engine.
// Depends on owm_pkg for the port widths, the command and phase enums and the result layout.
module testbench;
  import owm_pkg::*;

  localparam int HOLD_CYCLES  = 200;   // long receiver hold-off for the backpressure test
  localparam int QUIET_LIMIT  = 2000;  // cycles with no beat on either side before giving up
  localparam int SEGMENT_BEATS = 100;  // tick beats per random segment

  // How the simulated bus answers while a command runs.
  typedef enum logic [1:0] {
    LINE_HIGH,   // nobody pulls the line low
    LINE_LOW,    // line stuck low
    LINE_NOISE,  // random level on every tick
    LINE_SLAVE   // a device that answers presence and returns a byte on reads
  } line_mode_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic [IN_USER_W-1:0]  s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  // Idling switch and hold-off requests, written by the test flow with nonblocking
  // assignments so that the receiver never sees them mid-step.
  logic idle_on     = 1'b1;
  int   hold_asked  = 0;
  int   hold_served = 0;
  int   hold_left   = 0;

  int          errors       = 0;
  int          items_sent   = 0;
  int unsigned quiet_cycles = 0;

  // Predictor state, starting at the values the block takes on reset.
  logic [15:0] rst_low_t  = 16'd480;
  logic [15:0] pres_win_t = 16'd480;
  logic [15:0] slot_t     = 16'd60;
  phase_t      ph         = PH_IDLE;
  cmd_t        cur_cmd    = CMD_NONE;
  logic [15:0] tick_cnt   = '0;
  logic [2:0]  bit_idx    = '0;
  logic [7:0]  shreg      = '0;
  logic        pres       = 1'b0;
  logic [7:0]  rd_byte    = '0;

  res_t expected_drive[$];

  onewire_master_slot_engine_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #6 clk = ~clk;

  // A phase of n ticks loads its down-counter with n - 1; a zero length counts as one tick.
  function automatic logic [15:0] ticks_to_load(logic [15:0] n);
    return (n == 16'd0) ? 16'd0 : n - 16'd1;
  endfunction

  // Advances the predictor by one tick and returns the drive beat the block owes for it.
  function automatic res_t drive_for_tick(cmd_t op, logic [7:0] wdata, logic line);
    res_t r;
    logic end_bit;
    r       = '0;
    end_bit = 1'b0;
    // A command is only taken when the engine is idle; its first tick is this one.
    if (ph == PH_IDLE && op != CMD_NONE) begin
      cur_cmd = op;
      bit_idx = 3'd0;
      if (op == CMD_RESET) begin
        pres     = 1'b0;
        ph       = PH_RST_LOW;
        tick_cnt = ticks_to_load(rst_low_t);
      end else begin
        if (op == CMD_WRITE) shreg = wdata;
        ph       = PH_LOW;
        tick_cnt = 16'd0;
      end
    end
    r.busy_res = (ph != PH_IDLE);
    case (ph)
      PH_RST_LOW: begin
        r.drive_enable = 1'b1;
        if (tick_cnt == 16'd0) begin
          ph       = PH_RST_WAIT;
          tick_cnt = ticks_to_load(pres_win_t);
        end else begin
          tick_cnt = tick_cnt - 16'd1;
        end
      end
      PH_RST_WAIT: begin
        if (!line) pres = 1'b1;
        if (tick_cnt == 16'd0) begin
          r.done_res = 1'b1;
          ph         = PH_IDLE;
        end else begin
          tick_cnt = tick_cnt - 16'd1;
        end
      end
      PH_LOW: begin
        r.drive_enable = 1'b1;
        if (cur_cmd == CMD_WRITE) begin
          ph       = PH_VALUE;
          tick_cnt = ticks_to_load(slot_t);
        end else begin
          ph = PH_REL;
        end
      end
      PH_VALUE: begin
        r.drive_enable = 1'b1;
        r.drive_level  = shreg[0];
        if (tick_cnt == 16'd0) ph = PH_REL;
        else tick_cnt = tick_cnt - 16'd1;
      end
      PH_REL: begin
        if (cur_cmd == CMD_WRITE) begin
          shreg   = shreg >> 1;
          end_bit = 1'b1;
        end else begin
          ph = PH_SAMPLE;
        end
      end
      PH_SAMPLE: begin
        // The bit arrives in the top and walks down, so the first bit ends up in bit 0.
        shreg = {line, shreg[7:1]};
        if (slot_t <= 16'd2) begin
          end_bit = 1'b1;
        end else begin
          ph       = PH_WAIT;
          tick_cnt = slot_t - 16'd3;
        end
      end
      PH_WAIT: begin
        if (tick_cnt == 16'd0) end_bit = 1'b1;
        else tick_cnt = tick_cnt - 16'd1;
      end
      default: ;
    endcase
    if (end_bit) begin
      if (bit_idx == 3'd7) begin
        if (cur_cmd == CMD_READ) rd_byte = shreg;
        r.done_res = 1'b1;
        ph         = PH_IDLE;
      end else begin
        bit_idx = bit_idx + 3'd1;
        ph      = PH_LOW;
      end
    end
    r.presence_seen = pres;
    r.read_data     = rd_byte;
    return r;
  endfunction

  // Line level for the coming tick, chosen from the phase the engine is about to be in.
  function automatic logic pick_line(line_mode_t mode, logic [7:0] pattern);
    case (mode)
      LINE_HIGH:  return 1'b1;
      LINE_LOW:   return 1'b0;
      LINE_NOISE: return 1'($urandom_range(1));
      default: begin
        if (ph == PH_RST_WAIT) return 1'b0;
        if (ph == PH_SAMPLE) return pattern[bit_idx];
        return 1'b1;
      end
    endcase
  endfunction

  task automatic report(string msg);
    if (errors < 100) $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) report($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  // Offers one tick beat from a falling edge and returns at the falling edge after it
  // was taken. Valid stays high on return so back-to-back beats need no extra edge.
  task automatic send_tick(cmd_t op, logic [7:0] wdata, logic line);
    while (idle_on && $urandom_range(99) < 23) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'd0, line, wdata};
    do @(posedge clk); while (!s_tready);
    expected_drive.push_back(drive_for_tick(op, wdata, line));
    items_sent++;
    @(negedge clk);
  endtask

  // Runs one command to its end. With stray set, some busy ticks carry commands
  // that the engine has to ignore.
  task automatic run_cmd(cmd_t op, logic [7:0] wdata, line_mode_t mode,
                         logic [7:0] pattern, logic stray);
    cmd_t extra;
    send_tick(op, wdata, pick_line(mode, pattern));
    while (ph != PH_IDLE) begin
      extra = CMD_NONE;
      if (stray && $urandom_range(99) < 15) extra = cmd_t'($urandom_range(3));
      send_tick(extra, 8'($urandom), pick_line(mode, pattern));
    end
  endtask

  // Finishes any command in progress, then stops sending until every drive beat is back.
  task automatic settle_bus();
    while (ph != PH_IDLE) send_tick(CMD_NONE, 8'($urandom), 1'b1);
    s_tvalid <= 1'b0;
    while (expected_drive.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Writes all three timing registers while the engine is idle.
  task automatic retime(logic [15:0] low_t, logic [15:0] win_t, logic [15:0] slot_len);
    settle_bus();
    cfg_we    <= 1'b1;
    cfg_index <= REG_RESET_LOW;
    cfg_data  <= low_t;
    @(negedge clk);
    cfg_index <= REG_PRESENCE;
    cfg_data  <= win_t;
    @(negedge clk);
    cfg_index <= REG_SLOT;
    cfg_data  <= slot_len;
    @(negedge clk);
    cfg_we     <= 1'b0;
    rst_low_t  = low_t;
    pres_win_t = win_t;
    slot_t     = slot_len;
    @(negedge clk);
  endtask

  task automatic test_defaults();
    // One read at the reset timing, before any register write, then an empty tick.
    run_cmd(CMD_READ, 8'h00, LINE_SLAVE, 8'hC3, 1'b0);
    send_tick(CMD_NONE, 8'hFF, 1'b0);
  endtask

  task automatic test_directed();
    retime(16'd1, 16'd1, 16'd2);
    run_cmd(CMD_RESET, 8'h00, LINE_SLAVE, 8'h00, 1'b0);   // presence answered
    run_cmd(CMD_RESET, 8'hFF, LINE_HIGH, 8'h00, 1'b1);    // no presence, flag clears
    run_cmd(CMD_WRITE, 8'hFF, LINE_HIGH, 8'h00, 1'b1);
    run_cmd(CMD_WRITE, 8'h00, LINE_LOW, 8'h00, 1'b1);
    run_cmd(CMD_READ, 8'hFF, LINE_SLAVE, 8'h5A, 1'b1);
    run_cmd(CMD_READ, 8'h00, LINE_LOW, 8'h00, 1'b0);
    run_cmd(CMD_READ, 8'h00, LINE_HIGH, 8'h00, 1'b0);
    // Zero lengths count as one tick; a read with no wait left takes only its sample.
    retime(16'd0, 16'd0, 16'd0);
    run_cmd(CMD_RESET, 8'h00, LINE_SLAVE, 8'h00, 1'b0);
    run_cmd(CMD_WRITE, 8'hA5, LINE_NOISE, 8'h00, 1'b0);
    run_cmd(CMD_READ, 8'h00, LINE_SLAVE, 8'h3C, 1'b0);
    retime(16'd2, 16'd3, 16'd1);
    run_cmd(CMD_READ, 8'h00, LINE_SLAVE, 8'h96, 1'b1);
    run_cmd(CMD_WRITE, 8'h81, LINE_HIGH, 8'h00, 1'b0);
    // Slot of three: the read waits exactly one further tick.
    retime(16'd3, 16'd2, 16'd3);
    run_cmd(CMD_READ, 8'h00, LINE_SLAVE, 8'h69, 1'b0);
    run_cmd(CMD_WRITE, 8'h7E, LINE_NOISE, 8'h00, 1'b1);
    run_cmd(CMD_RESET, 8'h00, LINE_NOISE, 8'h00, 1'b1);
  endtask

  task automatic test_random();
    int goal;
    for (int seg = 0; seg < 6; seg++) begin
      retime(16'($urandom_range(6)), 16'($urandom_range(6)), 16'($urandom_range(7)));
      // The fourth segment runs without any idling on either side.
      idle_on <= (seg != 3);
      goal = items_sent + SEGMENT_BEATS;
      while (items_sent < goal) begin
        if ($urandom_range(99) < 70)
          run_cmd(cmd_t'($urandom_range(3, 1)), 8'($urandom),
                  line_mode_t'($urandom_range(3)), 8'($urandom), 1'($urandom_range(1)));
        else
          send_tick(CMD_NONE, 8'($urandom), 1'($urandom_range(1)));
      end
    end
    idle_on <= 1'b1;
  endtask

  task automatic test_backpressure();
    retime(16'd2, 16'd2, 16'd3);
    // The receiver holds off while the commands keep coming, so the input stalls.
    hold_asked <= hold_asked + 1;
    for (int k = 0; k < 4; k++)
      run_cmd(cmd_t'($urandom_range(3, 1)), 8'($urandom), LINE_NOISE, 8'($urandom), 1'b1);
    repeat (20) send_tick(CMD_NONE, 8'($urandom), 1'($urandom_range(1)));
    // The sender then waits until every drive beat has come back.
    settle_bus();
    run_cmd(CMD_READ, 8'($urandom), LINE_SLAVE, 8'($urandom), 1'b1);
  endtask

  task automatic test_extremes();
    // Longer phases with counts well past the low bits, run without idling.
    retime(16'd30, 16'd25, 16'd12);
    idle_on <= 1'b0;
    run_cmd(CMD_RESET, 8'h00, LINE_NOISE, 8'h00, 1'b1);
    run_cmd(CMD_READ, 8'h00, LINE_SLAVE, 8'($urandom), 1'b1);
    idle_on <= 1'b1;
    retime(16'd1, 16'd2, 16'd2);
    run_cmd(CMD_WRITE, 8'($urandom), LINE_NOISE, 8'h00, 1'b1);
    run_cmd(CMD_RESET, 8'h00, LINE_NOISE, 8'h00, 1'b0);
  endtask

  // Receiver: random ready, or a long hold-off when the test flow asks for one.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_served) begin
      m_tready    <= 1'b0;
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_asked;
    end else begin
      m_tready <= !(idle_on && $urandom_range(99) < 23);
    end
  end

  // Every drive beat taken is matched with the oldest expectation.
  always @(posedge clk) begin : check_beats
    res_t got;
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = res_t'(m_tdata[RES_W-1:0]);
      if (expected_drive.size() == 0) begin
        report($sformatf("unexpected drive beat %0h", m_tdata));
      end else begin
        want = expected_drive.pop_front();
        check_field("drive_enable", 8'(got.drive_enable), 8'(want.drive_enable));
        check_field("drive_level", 8'(got.drive_level), 8'(want.drive_level));
        check_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
        check_field("done_res", 8'(got.done_res), 8'(want.done_res));
        check_field("presence_seen", 8'(got.presence_seen), 8'(want.presence_seen));
        check_field("read_data", got.read_data, want.read_data);
      end
    end
  end

  // Watchdog on progress: any beat on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_defaults();
    test_directed();
    test_random();
    test_backpressure();
    test_extremes();
    s_tvalid <= 1'b0;
    while (expected_drive.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/owm_pkg.sv
src/owm_front.sv
src/owm_back.sv
src/onewire_master_slot_engine_unit.sv
tb/sv/testbench.sv
